### rtl/mqttd_pkg.sv
`default_nettype none
package mqttd_pkg;

   localparam int MAX_LENGTH_DIGITS = 4;

   localparam logic [3:0] TYPE_CONNACK    = 4'd2;
   localparam logic [3:0] TYPE_PUBLISH    = 4'd3;
   localparam logic [3:0] TYPE_PUBACK     = 4'd4;
   localparam logic [3:0] TYPE_PINGRESP   = 4'd13;
   localparam logic [3:0] TYPE_DISCONNECT = 4'd14;

   localparam logic [7:0] LEN_DATA_MASK = 8'h7F;

   typedef enum logic [1:0] {
      PH_TYPE    = 2'd0,
      PH_LEN     = 2'd1,
      PH_BODY    = 2'd2,
      PH_DISCARD = 2'd3
   } phase_type;

   typedef enum logic [3:0] {
      EV_CONNACK_OK     = 4'd0,
      EV_CONNACK_REFUSE = 4'd1,
      EV_CONNACK_SHORT  = 4'd2,
      EV_PUBACK         = 4'd3,
      EV_PUBACK_SHORT   = 4'd4,
      EV_PINGRESP       = 4'd5,
      EV_DISCONNECT     = 4'd6,
      EV_PUBLISH        = 4'd7,
      EV_OTHER          = 4'd8,
      EV_BAD_LENGTH     = 4'd9
   } event_type;

   typedef struct packed {
      event_type   event_res;
      logic [3:0]  packet_type;
      logic [3:0]  header_flags;
      logic [27:0] body_length;
      logic [7:0]  return_code;
      logic [15:0] ack_id;
   } result_type;

endpackage
`default_nettype wire

### rtl/mqttd_rsp_buf.sv
`default_nettype none
// Two-entry result buffer: an output register plus a skid register so the
// request side keeps flowing while a result waits.
module mqttd_rsp_buf (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  wire mqttd_pkg::result_type push_data,
   output logic                 full,
   output logic                 out_valid,
   input  wire                  out_ready,
   output mqttd_pkg::result_type out_data
);

   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   mqttd_pkg::result_type out_data_ff, out_data_in;
   mqttd_pkg::result_type skid_data_ff, skid_data_in;
   logic                  pop;

   assign pop       = out_valid_ff & out_ready;
   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff) begin
         out_valid_in = push;
         out_data_in  = push_data;
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule
`default_nettype wire

### rtl/mqtt_rx_packet_deframer_unit.sv
`default_nettype none
// MQTT 3.1.1 receive deframer. Each request carries one received byte
// (action 0) or a clear (action 1) that drops any partial packet and leaves
// the discard state. Every request is consumed by a single
// state update; when a packet's last byte arrives (its length byte for a
// zero remaining length, else its last body byte) one classified event is
// written to the result buffer, whose output register and skid register let
// a new request be taken every cycle, even while a result waits. Only when
// both buffer entries are occupied does req_ready drop. A continuation bit
// on the fourth length byte reports bad length once, then bytes are
// discarded until a clear.
module mqtt_rx_packet_deframer_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_action,
   input  wire  [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [3:0]  rsp_event_res,
   output logic [3:0]  rsp_packet_type,
   output logic [3:0]  rsp_header_flags,
   output logic [27:0] rsp_body_length,
   output logic [7:0]  rsp_return_code,
   output logic [15:0] rsp_ack_id
);

   mqttd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  type_byte_ff, type_byte_in;
   logic [27:0] accum_ff, accum_in;
   logic [2:0]  digits_ff, digits_in;
   logic [27:0] left_ff, left_in;
   logic [1:0]  seen_ff, seen_in;
   logic [15:0] ftb_ff, ftb_in;

   logic        accept, take_byte, buf_full;
   logic [27:0] digit_add, acc_next, left_dec;
   logic [2:0]  digits_next;
   logic [1:0]  seen_upd;
   logic [15:0] ftb_upd;
   logic        len_last, too_long, emit_pkt, emit_bad;
   logic [1:0]  seen_e;
   logic [15:0] ftb_e;
   mqttd_pkg::result_type result;

   assign req_ready = ~buf_full;
   assign accept    = req_valid & req_ready;
   assign take_byte = accept & ~req_action;

   always_comb begin
      case (digits_ff[1:0])
         2'd0:    digit_add = {21'd0, req_rx_byte[6:0]};
         2'd1:    digit_add = {14'd0, req_rx_byte[6:0], 7'd0};
         2'd2:    digit_add = {7'd0, req_rx_byte[6:0], 14'd0};
         default: digit_add = {req_rx_byte[6:0], 21'd0};
      endcase
   end

   assign acc_next    = accum_ff + digit_add;
   assign digits_next = digits_ff + 3'd1;
   assign left_dec    = left_ff - 28'd1;
   assign seen_upd    = (seen_ff < 2'd2) ? seen_ff + 2'd1 : seen_ff;
   assign ftb_upd     = (seen_ff < 2'd2) ? {ftb_ff[7:0], req_rx_byte} : ftb_ff;

   assign len_last = (phase_ff == mqttd_pkg::PH_LEN) & ~req_rx_byte[7];
   assign too_long = (phase_ff == mqttd_pkg::PH_LEN) & req_rx_byte[7]
                   & (digits_next >= 3'(mqttd_pkg::MAX_LENGTH_DIGITS));
   assign emit_pkt = take_byte & ((len_last & (acc_next == 28'd0))
                   | ((phase_ff == mqttd_pkg::PH_BODY) & (left_dec == 28'd0)));
   assign emit_bad = take_byte & too_long;

   // next state
   always_comb begin
      phase_in     = phase_ff;
      type_byte_in = type_byte_ff;
      accum_in     = accum_ff;
      digits_in    = digits_ff;
      left_in      = left_ff;
      seen_in      = seen_ff;
      ftb_in       = ftb_ff;
      if (accept && req_action) begin
         phase_in     = mqttd_pkg::PH_TYPE;
         type_byte_in = 8'd0;
         accum_in     = 28'd0;
         digits_in    = 3'd0;
         left_in      = 28'd0;
         seen_in      = 2'd0;
         ftb_in       = 16'd0;
      end else if (take_byte) begin
         case (phase_ff)
            mqttd_pkg::PH_TYPE: begin
               type_byte_in = req_rx_byte;
               accum_in     = 28'd0;
               digits_in    = 3'd0;
               left_in      = 28'd0;
               seen_in      = 2'd0;
               ftb_in       = 16'd0;
               phase_in     = mqttd_pkg::PH_LEN;
            end
            mqttd_pkg::PH_LEN: begin
               accum_in  = acc_next;
               digits_in = digits_next;
               if (len_last) begin
                  if (acc_next == 28'd0) begin
                     phase_in = mqttd_pkg::PH_TYPE;
                  end else begin
                     left_in  = acc_next;
                     seen_in  = 2'd0;
                     phase_in = mqttd_pkg::PH_BODY;
                  end
               end else if (too_long) begin
                  phase_in = mqttd_pkg::PH_DISCARD;
               end
            end
            mqttd_pkg::PH_BODY: begin
               seen_in = seen_upd;
               ftb_in  = ftb_upd;
               left_in = left_dec;
               if (left_dec == 28'd0) begin
                  phase_in = mqttd_pkg::PH_TYPE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // event classification
   always_comb begin
      seen_e = (phase_ff == mqttd_pkg::PH_BODY) ? seen_upd : 2'd0;
      ftb_e  = (phase_ff == mqttd_pkg::PH_BODY) ? ftb_upd : 16'd0;
      result.packet_type  = type_byte_ff[7:4];
      result.header_flags = type_byte_ff[3:0];
      result.body_length  = (phase_ff == mqttd_pkg::PH_LEN) ? acc_next : accum_ff;
      result.return_code  = 8'd0;
      result.ack_id       = 16'd0;
      case (type_byte_ff[7:4])
         mqttd_pkg::TYPE_CONNACK: begin
            if (seen_e < 2'd2) begin
               result.event_res = mqttd_pkg::EV_CONNACK_SHORT;
            end else begin
               result.return_code = ftb_e[7:0];
               result.event_res   = (ftb_e[7:0] == 8'd0) ? mqttd_pkg::EV_CONNACK_OK
                                                         : mqttd_pkg::EV_CONNACK_REFUSE;
            end
         end
         mqttd_pkg::TYPE_PUBACK: begin
            if (seen_e < 2'd2) begin
               result.event_res = mqttd_pkg::EV_PUBACK_SHORT;
            end else begin
               result.event_res = mqttd_pkg::EV_PUBACK;
               result.ack_id    = ftb_e;
            end
         end
         mqttd_pkg::TYPE_PINGRESP:   result.event_res = mqttd_pkg::EV_PINGRESP;
         mqttd_pkg::TYPE_DISCONNECT: result.event_res = mqttd_pkg::EV_DISCONNECT;
         mqttd_pkg::TYPE_PUBLISH:    result.event_res = mqttd_pkg::EV_PUBLISH;
         default:                    result.event_res = mqttd_pkg::EV_OTHER;
      endcase
      if (emit_bad) begin
         result.event_res   = mqttd_pkg::EV_BAD_LENGTH;
         result.body_length = 28'd0;
         result.return_code = 8'd0;
         result.ack_id      = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= mqttd_pkg::PH_TYPE;
         type_byte_ff <= 8'd0;
         accum_ff     <= 28'd0;
         digits_ff    <= 3'd0;
         left_ff      <= 28'd0;
         seen_ff      <= 2'd0;
         ftb_ff       <= 16'd0;
      end else begin
         phase_ff     <= phase_in;
         type_byte_ff <= type_byte_in;
         accum_ff     <= accum_in;
         digits_ff    <= digits_in;
         left_ff      <= left_in;
         seen_ff      <= seen_in;
         ftb_ff       <= ftb_in;
      end
   end

   mqttd_pkg::result_type out_data;

   mqttd_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (emit_pkt | emit_bad),
      .push_data (result),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_event_res    = out_data.event_res;
   assign rsp_packet_type  = out_data.packet_type;
   assign rsp_header_flags = out_data.header_flags;
   assign rsp_body_length  = out_data.body_length;
   assign rsp_return_code  = out_data.return_code;
   assign rsp_ack_id       = out_data.ack_id;

endmodule
`default_nettype wire
